// ===== sv/clkrc_pkg.sv =====
// ---------------------------------------------------------------------------
// clkrc_pkg
// Shared types for the second-chance clock replacement tag cache: controller
// states and the command / status bundles between controller and datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package clkrc_pkg;

  // field widths of the key, result and config words
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned CFG_W  = 5;

  // entries_in_use after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SWEEP,
    ST_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic start;       // latch key, restart the tag probe
    logic commit_hit;  // set reference bit of hit slot, count hit
    logic sweep_step;  // clear reference bit under hand, advance hand
    logic install;     // write key under hand, count miss
    logic load_out;    // move pending result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;         // probed slot is valid and holds the key
    logic search_end;  // probed slot is the last active slot
    logic ref_set;     // slot under the hand has its reference bit set
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== sv/clkrc_ctrl.sv =====
// ---------------------------------------------------------------------------
// clkrc_ctrl
// Controller: sequences search, clock sweep and result hand-off for one
// word at a time and owns the handshake state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clkrc_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire                  out_stall,
  input  clkrc_pkg::dp_sts_t   sts,
  output clkrc_pkg::ctrl_cmd_t cmd
);

  clkrc_pkg::ctrl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= clkrc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    in_stall      = 1'b1;
    unique case (state_r)
      clkrc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = clkrc_pkg::ST_SEARCH;
        end
      end
      clkrc_pkg::ST_SEARCH: begin
        if (sts.hit) begin
          cmd.commit_hit = 1'b1;
          state_nxt      = clkrc_pkg::ST_FIN;
        end else if (sts.search_end) begin
          state_nxt = clkrc_pkg::ST_SWEEP;
        end
      end
      clkrc_pkg::ST_SWEEP: begin
        if (sts.ref_set) begin
          cmd.sweep_step = 1'b1;
        end else begin
          cmd.install = 1'b1;
          state_nxt   = clkrc_pkg::ST_FIN;
        end
      end
      clkrc_pkg::ST_FIN: begin
        // output register free or being drained this cycle
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = clkrc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = clkrc_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== sv/clkrc_dp.sv =====
// ---------------------------------------------------------------------------
// clkrc_dp
// Datapath: tag memory, valid and reference bits, clock hand, probe
// pointer, saturating counters, config register and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clkrc_dp #(
  parameter int unsigned SLOTS    = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire  [clkrc_pkg::CFG_W-1:0]      cfg_wdata,
  input  wire  [clkrc_pkg::KEY_W-1:0]      in_lookup_key,
  input  clkrc_pkg::ctrl_cmd_t             cmd,
  output clkrc_pkg::dp_sts_t               sts,
  output logic                             out_was_hit,
  output logic [clkrc_pkg::SLOT_W-1:0]     out_slot_index,
  output logic [clkrc_pkg::CNT_W-1:0]      out_hit_total,
  output logic [clkrc_pkg::CNT_W-1:0]      out_miss_total
);

  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned NW    = $clog2(SLOTS + 1);
  localparam int unsigned EW    = (NW > clkrc_pkg::CFG_W) ? NW : clkrc_pkg::CFG_W;
  localparam int unsigned TAG_W = (KEY_BITS < clkrc_pkg::KEY_W) ? KEY_BITS
                                                                : clkrc_pkg::KEY_W;
  localparam logic [clkrc_pkg::CNT_W-1:0] CNT_MAX = '1;

  // config and active slot count
  logic [clkrc_pkg::CFG_W-1:0] cfg_r;
  logic [EW-1:0]               cfg_ext;
  logic [NW-1:0]               n_act;

  // tag store and per-slot bits
  logic [TAG_W-1:0] tag_mem [SLOTS];
  logic [SLOTS-1:0] valid_r;
  logic [SLOTS-1:0] ref_r;

  // probe pipeline
  logic [TAG_W-1:0] key_r;
  logic [NW-1:0]    idx_r;
  logic [SW-1:0]    pidx_r;
  logic             probe_r;
  logic             vld_q_r;
  logic [TAG_W-1:0] tag_q_r;
  logic             issue;

  // clock hand
  logic [SW-1:0] hand_r;
  logic [SW-1:0] h_cur;
  logic [NW-1:0] h_inc;
  logic [SW-1:0] h_next;

  // counters and pending result
  logic [clkrc_pkg::CNT_W-1:0] hit_cnt_r;
  logic [clkrc_pkg::CNT_W-1:0] miss_cnt_r;
  logic                        res_hit_r;
  logic [SW-1:0]               res_slot_r;
  logic [SW+clkrc_pkg::SLOT_W-1:0] slot_ext;

  always_comb begin
    cfg_ext = EW'(cfg_r);
    if (cfg_ext == '0) begin
      n_act = NW'(1);
    end else if (cfg_ext > EW'(SLOTS)) begin
      n_act = NW'(SLOTS);
    end else begin
      n_act = NW'(cfg_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= clkrc_pkg::CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  // one slot probed per cycle, tag read data registered
  assign issue = (idx_r < n_act);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= 1'b0;
      idx_r   <= '0;
    end else if (cmd.start) begin
      probe_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      probe_r <= issue;
      if (issue) begin
        idx_r <= idx_r + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r <= in_lookup_key[TAG_W-1:0];
    end
    pidx_r  <= idx_r[SW-1:0];
    vld_q_r <= valid_r[idx_r[SW-1:0]];
    tag_q_r <= tag_mem[idx_r[SW-1:0]];
    if (cmd.install) begin
      tag_mem[h_cur] <= key_r;
    end
  end

  // hand is restarted at slot 0 when it lies beyond the active range
  always_comb begin
    h_cur  = (NW'(hand_r) >= n_act) ? '0 : hand_r;
    h_inc  = NW'(h_cur) + NW'(1);
    h_next = (h_inc >= n_act) ? '0 : h_inc[SW-1:0];
  end

  always_comb begin
    sts.hit        = probe_r && vld_q_r && (tag_q_r == key_r);
    sts.search_end = probe_r && ((NW'(pidx_r) + NW'(1)) == n_act);
    sts.ref_set    = ref_r[h_cur];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      ref_r      <= '0;
      hand_r     <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
    end else begin
      if (cmd.commit_hit) begin
        ref_r[pidx_r] <= 1'b1;
        if (hit_cnt_r != CNT_MAX) begin
          hit_cnt_r <= hit_cnt_r + 1'b1;
        end
      end
      if (cmd.sweep_step) begin
        ref_r[h_cur] <= 1'b0;
        hand_r       <= h_next;
      end
      if (cmd.install) begin
        ref_r[h_cur]   <= 1'b1;
        valid_r[h_cur] <= 1'b1;
        hand_r         <= h_cur;
        if (miss_cnt_r != CNT_MAX) begin
          miss_cnt_r <= miss_cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_hit) begin
      res_hit_r  <= 1'b1;
      res_slot_r <= pidx_r;
    end else if (cmd.install) begin
      res_hit_r  <= 1'b0;
      res_slot_r <= h_cur;
    end
  end

  assign slot_ext = {{clkrc_pkg::SLOT_W{1'b0}}, res_slot_r};

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_was_hit    <= res_hit_r;
      out_slot_index <= slot_ext[clkrc_pkg::SLOT_W-1:0];
      out_hit_total  <= hit_cnt_r;
      out_miss_total <= miss_cnt_r;
    end
  end

endmodule

`default_nettype wire

// ===== sv/clock_replacement_cache.sv =====
// ---------------------------------------------------------------------------
// clock_replacement_cache
// Tag cache with second-chance (clock) replacement, hit/miss counters.
//
//   port group  dir  handshake        payload
//   in_         in   valid / stall    lookup_key
//   out_        out  valid / stall    was_hit, slot_index, hit_total,
//                                     miss_total
//   cfg_        in   we               wdata = entries_in_use
//
// A word is taken only while the block is idle. Tag search reads one slot
// per cycle from the tag memory across the n active slots, stopping early
// on a hit; a miss then sweeps the clock hand one slot per cycle until it
// finds a slot whose reference bit is clear.
// Reset is synchronous and clears valid/reference bits, hand and counters.
// A stalled result holds in the output register; the block waits before
// loading the next one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clock_replacement_cache #(
  parameter int unsigned SLOTS    = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire  [clkrc_pkg::CFG_W-1:0]      cfg_wdata,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [clkrc_pkg::KEY_W-1:0]      in_lookup_key,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             out_was_hit,
  output logic [clkrc_pkg::SLOT_W-1:0]     out_slot_index,
  output logic [clkrc_pkg::CNT_W-1:0]      out_hit_total,
  output logic [clkrc_pkg::CNT_W-1:0]      out_miss_total
);

  clkrc_pkg::ctrl_cmd_t cmd;
  clkrc_pkg::dp_sts_t   sts;

  clkrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  clkrc_dp #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_lookup_key  (in_lookup_key),
    .cmd            (cmd),
    .sts            (sts),
    .out_was_hit    (out_was_hit),
    .out_slot_index (out_slot_index),
    .out_hit_total  (out_hit_total),
    .out_miss_total (out_miss_total)
  );

  // accepted word blocks further input until its result is loaded
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after accept");

  // a word either hits or installs, never both
  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.commit_hit && cmd.install))
    else $error("hit commit and install in same cycle");

  // install only on a slot whose reference bit is clear
  a_install_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.install |-> !sts.ref_set)
    else $error("install over a referenced slot");

  // result is loaded only while nothing waits or the waiting word drains
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !out_valid || !out_stall)
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire
